>>> rtl/dmlw_pkg.sv
// Package for the DNS message length walker: walk phases, status codes, limits.
// No dependencies; imported by the interface file and the top level.
`default_nettype none

package dmlw_pkg;

  // Payload widths
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 2;

  // Internal counter widths
  localparam int unsigned HIDX_W = 4;
  localparam int unsigned REC_W  = 18;
  localparam int unsigned FIX_W  = 4;

  // Length saturation limit
  localparam logic [LEN_W-1:0] MAX_MSG_BYTES = 16'hFFFF;

  // Header layout and fixed section sizes
  localparam logic [HIDX_W-1:0] HDR_LAST_IDX    = 4'd11;
  localparam logic [HIDX_W-1:0] HDR_QD_HI_IDX   = 4'd4;
  localparam logic [HIDX_W-1:0] HDR_QD_LO_IDX   = 4'd5;
  localparam logic [HIDX_W-1:0] HDR_CNT_LO_IDX  = 4'd6;
  localparam logic [FIX_W-1:0]  QFIXED_LEN      = 4'd4;
  localparam logic [FIX_W-1:0]  RFIXED_LEN      = 4'd10;
  localparam logic [FIX_W-1:0]  RDLEN_HI_IDX    = 4'd8;
  localparam logic [FIX_W-1:0]  NAME_ENDS_MARK  = 4'd1;
  localparam logic [DATA_W-1:0] PTR_BYTE        = 8'hC0;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_WHOLE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRAILING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd2;

  // Walk phases, one-hot
  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_QNAME  = 8'b0000_0010,
    PH_QFIXED = 8'b0000_0100,
    PH_RNAME  = 8'b0000_1000,
    PH_LABEL  = 8'b0001_0000,
    PH_RFIXED = 8'b0010_0000,
    PH_RDATA  = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/dmlw_if.sv
// Valid/ready channel interfaces for the DNS message length walker.
// Depends on dmlw_pkg for payload widths.
`default_nettype none

// Input channel: one message byte per request
interface dmlw_in_if import dmlw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel: one request per message
interface dmlw_out_if import dmlw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEN_W-1:0]    consumed_len;
  logic [STATUS_W-1:0] msg_status;

  modport source (output valid, output consumed_len, output msg_status, input ready);
  modport sink   (input valid, input consumed_len, input msg_status, output ready);
endinterface

`default_nettype wire

>>> rtl/dns_message_length_walker_unit.sv
// Top level of the DNS message length walker: byte walker and result register.
// Depends on dmlw_pkg and the channel interfaces in dmlw_if.sv.
//
//   channel   dir   payload                             request
//   in_if     in    data_byte[7:0], last_byte           one message byte
//   out_if    out   consumed_len[15:0], msg_status[1:0] one result per message
//
// One byte is taken per cycle while in_if.ready is high; the walk state updates in the same cycle.
// A byte marked last loads the result register; the walk state returns
// to its header phase at that edge, so the next message may start next cycle.
// in_if.ready drops only while a result waits and out_if.ready is low.
// rst_n is synchronous, active low, and clears the walk state and out valid.
`default_nettype none

module dns_message_length_walker_unit import dmlw_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  dmlw_in_if.sink     in_if,
  dmlw_out_if.source  out_if
);

  phase_t              phase_r,   phase_nxt;
  logic [HIDX_W-1:0]   hidx_r,    hidx_nxt;
  logic [LEN_W-1:0]    qleft_r,   qleft_nxt;
  logic [REC_W-1:0]    rleft_r,   rleft_nxt;
  logic [LEN_W-1:0]    skip_r,    skip_nxt;
  logic [FIX_W-1:0]    fidx_r,    fidx_nxt;
  logic [DATA_W-1:0]   rdhi_r,    rdhi_nxt;
  logic [LEN_W-1:0]    count_r,   count_nxt;

  logic                out_valid_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                accept;
  logic                was_done;
  logic                short_hdr;
  logic [DATA_W-1:0]   b;
  logic [REC_W-1:0]    rec_sum;
  logic [REC_W-1:0]    rec_dec;
  logic [LEN_W-1:0]    q_dec;
  logic [LEN_W-1:0]    skip_dec;
  logic [FIX_W-1:0]    fidx_inc;
  logic [LEN_W-1:0]    rdlen;

  // Take a byte unless a result is stuck in the output register
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign b           = in_if.data_byte;

  assign was_done  = (phase_r == PH_DONE);
  assign short_hdr = (phase_r == PH_HEADER) && (hidx_r < HDR_LAST_IDX);

  assign rec_sum  = rleft_r + {{(REC_W-LEN_W){1'b0}}, rdhi_r, b};
  assign rec_dec  = rleft_r - {{(REC_W-1){1'b0}}, 1'b1};
  assign q_dec    = qleft_r - {{(LEN_W-1){1'b0}}, 1'b1};
  assign skip_dec = skip_r - {{(LEN_W-1){1'b0}}, 1'b1};
  assign fidx_inc = fidx_r + {{(FIX_W-1){1'b0}}, 1'b1};
  assign rdlen    = {rdhi_r, b};

  // Walk one byte through the header and sections
  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    qleft_nxt = qleft_r;
    rleft_nxt = rleft_r;
    skip_nxt  = skip_r;
    fidx_nxt  = fidx_r;
    rdhi_nxt  = rdhi_r;
    count_nxt = count_r;

    if (!was_done && count_r < MAX_MSG_BYTES) begin
      count_nxt = count_r + {{(LEN_W-1){1'b0}}, 1'b1};
    end

    case (phase_r)
      PH_HEADER: begin
        if (hidx_r == HDR_QD_HI_IDX || hidx_r == HDR_QD_LO_IDX) begin
          qleft_nxt = {qleft_r[LEN_W-DATA_W-1:0], b};
        end else if (hidx_r >= HDR_CNT_LO_IDX && hidx_r <= HDR_LAST_IDX) begin
          if (!hidx_r[0]) begin
            rdhi_nxt = b;
          end else begin
            rleft_nxt = rec_sum;
          end
        end
        if (hidx_r >= HDR_LAST_IDX) begin
          rdhi_nxt = '0;
          if (qleft_r != '0) begin
            phase_nxt = PH_QNAME;
          end else if (rec_sum != '0) begin
            phase_nxt = PH_RNAME;
          end else begin
            phase_nxt = PH_DONE;
          end
        end else begin
          hidx_nxt = hidx_r + {{(HIDX_W-1){1'b0}}, 1'b1};
        end
      end
      PH_QNAME: begin
        if (b == '0) begin
          fidx_nxt  = '0;
          phase_nxt = PH_QFIXED;
        end
      end
      PH_QFIXED: begin
        fidx_nxt = fidx_inc;
        if (fidx_inc >= QFIXED_LEN) begin
          fidx_nxt  = '0;
          qleft_nxt = q_dec;
          if (q_dec != '0) begin
            phase_nxt = PH_QNAME;
          end else if (rleft_r != '0) begin
            phase_nxt = PH_RNAME;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_RNAME: begin
        if (b == PTR_BYTE) begin
          // Pointer: one more byte, then the name ends
          skip_nxt  = {{(LEN_W-1){1'b0}}, 1'b1};
          fidx_nxt  = NAME_ENDS_MARK;
          phase_nxt = PH_LABEL;
        end else if (b == '0) begin
          fidx_nxt  = '0;
          phase_nxt = PH_RFIXED;
        end else begin
          skip_nxt  = {{(LEN_W-DATA_W){1'b0}}, b};
          fidx_nxt  = '0;
          phase_nxt = PH_LABEL;
        end
      end
      PH_LABEL: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          if (fidx_r == NAME_ENDS_MARK) begin
            fidx_nxt  = '0;
            phase_nxt = PH_RFIXED;
          end else begin
            phase_nxt = PH_RNAME;
          end
        end
      end
      PH_RFIXED: begin
        if (fidx_r == RDLEN_HI_IDX) begin
          rdhi_nxt = b;
        end
        fidx_nxt = fidx_inc;
        if (fidx_inc >= RFIXED_LEN) begin
          fidx_nxt = '0;
          skip_nxt = rdlen;
          rdhi_nxt = '0;
          if (rdlen != '0) begin
            phase_nxt = PH_RDATA;
          end else begin
            rleft_nxt = rec_dec;
            phase_nxt = (rec_dec != '0) ? PH_RNAME : PH_DONE;
          end
        end
      end
      PH_RDATA: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          rleft_nxt = rec_dec;
          phase_nxt = (rec_dec != '0) ? PH_RNAME : PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the walk state on each accepted byte; clear it on reset and after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_if.last_byte)) begin
      phase_r <= PH_HEADER;
      hidx_r  <= '0;
      qleft_r <= '0;
      rleft_r <= '0;
      skip_r  <= '0;
      fidx_r  <= '0;
      rdhi_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      qleft_r <= qleft_nxt;
      rleft_r <= rleft_nxt;
      skip_r  <= skip_nxt;
      fidx_r  <= fidx_nxt;
      rdhi_r  <= rdhi_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_if.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload on the last byte
  always_ff @(posedge clk) begin
    if (accept && in_if.last_byte) begin
      if (short_hdr) begin
        out_len_r    <= '0;
        out_status_r <= ST_SHORT;
      end else begin
        out_len_r    <= count_nxt;
        out_status_r <= was_done ? ST_TRAILING : ST_WHOLE;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.consumed_len = out_len_r;
  assign out_if.msg_status   = out_status_r;

endmodule

`default_nettype wire
